[rtl/cwrt_pkg.sv]
package cwrt_pkg;

  // Datapath width of the CORDIC registers (Q30 angles and vectors with headroom)
  localparam int CW = 36;

  // Digit pairs of the square root operand (62-bit radicand, 31-bit root)
  localparam int SQ_DIGITS = 31;

  // Q30 angle constants
  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;

  // Q30 unity for the haversine term
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Multiplier constants: pi/180 * 2^32, 2 * 6371 * 256, ceil(2^26 / 10)
  localparam logic signed [31:0] DEG_TO_RAD_K = 32'sd74961321;
  localparam logic signed [31:0] DIST_K       = 32'sd3261952;
  localparam logic signed [31:0] DIV10_K      = 32'sd6710887;

  // Largest distance code
  localparam logic [22:0] DIST_MAX = 23'h7F_FFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_STATION_LAT   = 2'd1;
  localparam logic [1:0] CFG_STATION_LON   = 2'd2;
  localparam logic [1:0] CFG_STATION_RANGE = 2'd3;

  // Configuration reset values
  localparam logic [7:0]         POLL_RESET  = 8'd5;
  localparam logic signed [23:0] SLAT_RESET  = 24'sd2621440;
  localparam logic signed [24:0] SLON_RESET  = -25'sd4849664;
  localparam logic [22:0]        RANGE_RESET = 23'd512000;

  typedef enum logic {
    CORD_ROT,
    CORD_VEC
  } cord_mode_t;

  typedef struct packed {
    logic       start;
    cord_mode_t mode;
  } cord_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Arctangent of 2^-i in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      5'd31: v = 30'd0;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/cwrt_cordic.sv]
module cwrt_cordic #(
  parameter int STEPS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cwrt_pkg::cord_ctl_t                ctl,
  input  logic signed [cwrt_pkg::CW-1:0]     x0,
  input  logic signed [cwrt_pkg::CW-1:0]     y0,
  input  logic signed [cwrt_pkg::CW-1:0]     z0,
  output logic signed [cwrt_pkg::CW-1:0]     x,
  output logic signed [cwrt_pkg::CW-1:0]     y,
  output logic signed [cwrt_pkg::CW-1:0]     z,
  output cwrt_pkg::unit_stat_t               stat
);
  import cwrt_pkg::*;

  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [CNT_W-1:0]     cnt_r;
  cord_mode_t           mode_r;
  logic                 busy_r, done_r;

  logic signed [CW-1:0] dx, dy, at;
  logic                 ccw;

  // One micro-rotation per cycle
  always_comb begin
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    at  = CW'(atan_q30(5'(cnt_r)));
    ccw = (mode_r == CORD_ROT) ? !z_r[CW-1] : y_r[CW-1];
  end

  // Load operands, then iterate until the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        x_r    <= x0;
        y_r    <= y0;
        z_r    <= z0;
        mode_r <= ctl.mode;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ccw) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign x         = x_r;
  assign y         = y_r;
  assign z         = z_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/cwrt_isqrt.sv]
module cwrt_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [2*cwrt_pkg::SQ_DIGITS-1:0] val,
  output logic [cwrt_pkg::SQ_DIGITS-1:0]   root,
  output cwrt_pkg::unit_stat_t          stat
);
  import cwrt_pkg::*;

  localparam int VW = 2 * SQ_DIGITS;
  localparam int RW = SQ_DIGITS + 2;
  localparam logic [4:0] LAST = 5'(SQ_DIGITS - 1);

  logic [VW-1:0]        v_r;
  logic [RW-1:0]        rem_r;
  logic [SQ_DIGITS-1:0] root_r;
  logic [4:0]           cnt_r;
  logic                 busy_r, done_r;

  logic [RW+1:0] rem_sh, trial;
  logic          fit;

  // Bring down the next digit pair and try the next root bit
  always_comb begin
    rem_sh = {rem_r, v_r[VW-1:VW-2]};
    trial  = (RW+2)'({root_r, 2'b01});
    fit    = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= val;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        v_r <= {v_r[VW-3:0], 2'b00};
        if (fit) begin
          rem_r  <= RW'(rem_sh - trial);
          root_r <= {root_r[SQ_DIGITS-2:0], 1'b1};
        end else begin
          rem_r  <= RW'(rem_sh);
          root_r <= {root_r[SQ_DIGITS-2:0], 1'b0};
        end
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/comm_window_range_tracker.sv]
// Non-poll tick: result valid the cycle after the input transfer.
// Poll tick: the result is computed on the shared CORDIC (four sin/cos runs and one atan2
// run) and the one-bit-per-cycle root unit.
// One tick is in work at a time; the next transfer is taken as the result leaves.
// Synchronous active-low reset: configuration registers return to reset values, held state clears.
module comm_window_range_tracker #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // fix_lat[23:0], fix_lon[48:24], fix_alt[68:49], zero fill
  input  logic        in_tuser,   // fix_ok
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // held_lat[23:0], held_lon[48:24], held_alt[68:49],
                                  // station_distance[91:69], in_window[92], zero fill
  output logic [1:0]  out_tuser,  // polled[0], poll_failed[1]
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_wdata
);
  import cwrt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANG_MUL, ST_ANG_RED, ST_ANG_RUN,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_A,
    ST_SQA_GO, ST_SQA_RUN, ST_SQB_GO, ST_SQB_RUN,
    ST_VEC_GO, ST_VEC_RUN, ST_D, ST_D2, ST_FLAG
  } state_t;

  // Configuration
  logic [7:0]         poll_r;
  logic signed [23:0] slat_r;
  logic signed [24:0] slon_r;
  logic [22:0]        range_r;

  // Held state
  state_t             state_r;
  logic [7:0]         tick_r;
  logic signed [23:0] cur_lat_r;
  logic signed [24:0] cur_lon_r;
  logic [19:0]        cur_alt_r;
  logic [22:0]        dist_r;
  logic               window_r;
  logic               out_valid_r, polled_r, failed_r;

  // Working registers
  logic [1:0]         ph_r;
  logic               neg_r;
  logic signed [63:0] p_r;
  logic signed [31:0] s1_r, s2_r, ca_r, cb_r, t1_r, t2_r, zc_r;
  logic [30:0]        a_r, ya_r, xb_r;

  // Shared units
  cord_ctl_t          cord_ctl;
  unit_stat_t         cord_stat, sq_stat;
  logic signed [CW-1:0] cx0, cy0, cz0, cx, cy, cz;
  logic               sq_start;
  logic [61:0]        sq_val;
  logic [30:0]        sq_root;

  logic               accept, poll;
  logic [8:0]         tick_next;
  logic signed [24:0] dlat;
  logic signed [25:0] dlon;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [CW-1:0] ang_h, ang, r1, rred;
  logic               rneg;
  logic signed [CW-1:0] cy_s, cx_s;
  logic signed [33:0] a_sum;
  logic signed [63:0] d_sum;
  logic [33:0]        d_q;
  logic [19:0]        q10;
  logic [23:0]        thr;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign tick_next = {1'b0, tick_r} + 9'd1;
  assign poll      = !(tick_next < {1'b0, poll_r});

  // Select multiplier operands and reduce the current angle
  always_comb begin
    dlat = 25'(slat_r) - 25'(cur_lat_r);
    dlon = 26'(slon_r) - 26'(cur_lon_r);
    unique case (state_r)
      ST_ANG_MUL: begin
        unique case (ph_r)
          2'd0: mul_a = 32'(dlat);
          2'd1: mul_a = 32'(dlon);
          2'd2: mul_a = 32'(cur_lat_r);
          2'd3: mul_a = 32'(slat_r);
          default: mul_a = '0;
        endcase
        mul_b = DEG_TO_RAD_K;
      end
      ST_T1: begin
        mul_a = s1_r;
        mul_b = s1_r;
      end
      ST_T2: begin
        mul_a = ca_r;
        mul_b = cb_r;
      end
      ST_T3: begin
        mul_a = s2_r;
        mul_b = s2_r;
      end
      ST_T4: begin
        mul_a = t2_r;
        mul_b = 32'(p_r >>> 30);
      end
      ST_D: begin
        mul_a = zc_r;
        mul_b = DIST_K;
      end
      ST_D2: begin
        mul_a = 32'({1'b0, range_r});
        mul_b = DIV10_K;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;

    // Half angle, doubled for the full-angle latitude terms
    ang_h = CW'(p_r >>> 19);
    ang   = ph_r[1] ? (ang_h <<< 1) : ang_h;
    // Wrap into [-pi, pi), then fold into [-pi/2, pi/2]
    if (ang >= PI_Q30) begin
      r1 = ang - TWO_PI_Q30;
    end else if (ang < -PI_Q30) begin
      r1 = ang + TWO_PI_Q30;
    end else begin
      r1 = ang;
    end
    if (r1 > HALF_PI_Q30) begin
      rred = r1 - PI_Q30;
      rneg = 1'b1;
    end else if (r1 < -HALF_PI_Q30) begin
      rred = r1 + PI_Q30;
      rneg = 1'b1;
    end else begin
      rred = r1;
      rneg = 1'b0;
    end

    // Shared unit control
    cord_ctl.start = (state_r == ST_ANG_RED) || (state_r == ST_VEC_GO);
    cord_ctl.mode  = (state_r == ST_VEC_GO) ? CORD_VEC : CORD_ROT;
    if (state_r == ST_VEC_GO) begin
      cx0 = CW'({1'b0, xb_r});
      cy0 = CW'({1'b0, ya_r});
      cz0 = '0;
    end else begin
      cx0 = CORDIC_GAIN;
      cy0 = '0;
      cz0 = rred;
    end
    sq_start = (state_r == ST_SQA_GO) || (state_r == ST_SQB_GO);
    sq_val   = (state_r == ST_SQB_GO) ? 62'({Q30_ONE - a_r, 30'b0}) : 62'({a_r, 30'b0});

    cy_s  = neg_r ? -cy : cy;
    cx_s  = neg_r ? -cx : cx;
    a_sum = 34'(t1_r) + 34'(p_r >>> 30);
    d_sum = p_r + 64'sd536870912;
    d_q   = d_sum[63:30];
    q10   = p_r[45:26];
    thr   = {1'b0, range_r} + 24'(q10);
  end

  cwrt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cord_ctl),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .x     (cx),
    .y     (cy),
    .z     (cz),
    .stat  (cord_stat)
  );

  cwrt_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (sq_val),
    .root  (sq_root),
    .stat  (sq_stat)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r  <= POLL_RESET;
      slat_r  <= SLAT_RESET;
      slon_r  <= SLON_RESET;
      range_r <= RANGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLL_INTERVAL: poll_r  <= cfg_wdata[7:0];
        CFG_STATION_LAT:   slat_r  <= cfg_wdata[23:0];
        CFG_STATION_LON:   slon_r  <= cfg_wdata[24:0];
        CFG_STATION_RANGE: range_r <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  // Sequencer, held state and result register
  always_ff @(posedge clk) begin
    p_r <= mul_p;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      cur_lat_r   <= '0;
      cur_lon_r   <= '0;
      cur_alt_r   <= '0;
      dist_r      <= '0;
      window_r    <= 1'b0;
      out_valid_r <= 1'b0;
      polled_r    <= 1'b0;
      failed_r    <= 1'b0;
      ph_r        <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (poll) begin
              tick_r   <= '0;
              polled_r <= 1'b1;
              failed_r <= !in_tuser;
              if (in_tuser) begin
                cur_lat_r <= in_tdata[23:0];
                cur_lon_r <= in_tdata[48:24];
                cur_alt_r <= in_tdata[68:49];
              end
              ph_r    <= '0;
              state_r <= ST_ANG_MUL;
            end else begin
              tick_r      <= tick_next[7:0];
              polled_r    <= 1'b0;
              failed_r    <= 1'b0;
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_ANG_MUL: state_r <= ST_ANG_RED;
        ST_ANG_RED: begin
          neg_r   <= rneg;
          state_r <= ST_ANG_RUN;
        end
        ST_ANG_RUN: begin
          if (cord_stat.done) begin
            unique case (ph_r)
              2'd0: s1_r <= 32'(cy_s);
              2'd1: s2_r <= 32'(cy_s);
              2'd2: ca_r <= 32'(cx_s);
              2'd3: cb_r <= 32'(cx_s);
              default: ;
            endcase
            ph_r    <= ph_r + 2'd1;
            state_r <= (ph_r == 2'd3) ? ST_T1 : ST_ANG_MUL;
          end
        end
        ST_T1: state_r <= ST_T2;
        ST_T2: begin
          t1_r    <= 32'(p_r >>> 30);
          state_r <= ST_T3;
        end
        ST_T3: begin
          t2_r    <= 32'(p_r >>> 30);
          state_r <= ST_T4;
        end
        ST_T4: state_r <= ST_A;
        ST_A: begin
          // Clamp the haversine term to [0, 1]
          if (a_sum < 0) begin
            a_r <= '0;
          end else if (a_sum > 34'(Q30_ONE)) begin
            a_r <= Q30_ONE;
          end else begin
            a_r <= 31'(a_sum);
          end
          state_r <= ST_SQA_GO;
        end
        ST_SQA_GO: state_r <= ST_SQA_RUN;
        ST_SQA_RUN: begin
          if (sq_stat.done) begin
            ya_r    <= sq_root;
            state_r <= ST_SQB_GO;
          end
        end
        ST_SQB_GO: state_r <= ST_SQB_RUN;
        ST_SQB_RUN: begin
          if (sq_stat.done) begin
            xb_r    <= sq_root;
            state_r <= ST_VEC_GO;
          end
        end
        ST_VEC_GO: state_r <= ST_VEC_RUN;
        ST_VEC_RUN: begin
          if (cord_stat.done) begin
            zc_r    <= cz[CW-1] ? '0 : 32'(cz);
            state_r <= ST_D;
          end
        end
        ST_D: state_r <= ST_D2;
        ST_D2: begin
          // Round and saturate the distance
          dist_r  <= (d_q > 34'(DIST_MAX)) ? DIST_MAX : d_q[22:0];
          state_r <= ST_FLAG;
        end
        ST_FLAG: begin
          // Hysteresis: enter below range, leave at range plus a tenth
          if (window_r) begin
            window_r <= ({1'b0, dist_r} < thr);
          end else begin
            window_r <= (dist_r < range_r);
          end
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, window_r, dist_r, cur_alt_r, cur_lon_r, cur_lat_r};
  assign out_tuser  = {failed_r, polled_r};

`ifndef ASSERT_OFF
  // Every transfer either yields a result next cycle or starts a poll computation
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_tvalid || state_r != ST_IDLE))
    else $error("accepted tick neither delivered nor in work");

  // The CORDIC and the root unit never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cord_stat.busy && sq_stat.busy))
    else $error("CORDIC and square root busy together");

  // The window flag only rises at the end of a poll computation
  a_window_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(window_r) |-> $past(state_r == ST_FLAG))
    else $error("window flag rose outside a poll");
`endif

endmodule
